FILE: rtl/core/i2c_register_transaction_sequencer_defines.svh
// Assertion macros for the I2C register transaction sequencer.
// Included by the top level only; depends on nothing else.
`ifndef I2C_REGISTER_TRANSACTION_SEQUENCER_DEFINES_SVH
`define I2C_REGISTER_TRANSACTION_SEQUENCER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define IRTS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define IRTS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/irts_pkg.sv
// Shared types and constants for the I2C register transaction sequencer.
// Used by irts_csr and the top level; depends on nothing.
package irts_pkg;

   localparam int TIMEOUT_W  = 16;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd10000;
   localparam logic [0:0] REG_TIMEOUT_LIMIT = 1'b0;

   localparam logic [1:0] KIND_CMD  = 2'd0;
   localparam logic [1:0] KIND_DONE = 2'd1;
   localparam logic [1:0] KIND_TICK = 2'd2;

   localparam logic [2:0] OP_NONE    = 3'd0;
   localparam logic [2:0] OP_START   = 3'd1;
   localparam logic [2:0] OP_RESTART = 3'd2;
   localparam logic [2:0] OP_SEND    = 3'd3;
   localparam logic [2:0] OP_RECV    = 3'd4;
   localparam logic [2:0] OP_ACK     = 3'd5;
   localparam logic [2:0] OP_NACK    = 3'd6;
   localparam logic [2:0] OP_STOP    = 3'd7;

   localparam logic [7:0] REG_AUTO_INC = 8'h80;
   localparam logic       ADDR_RD_BIT  = 1'b1;

   typedef struct packed {
      logic [1:0] kind;
      logic       is_read;
      logic [6:0] dev_address;
      logic [7:0] reg_index;
      logic [7:0] write_data;
      logic [7:0] length;
      logic       ack_seen;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic [2:0] bus_op;
      logic [7:0] bus_byte;
      logic       rx_valid;
      logic [7:0] rx_data;
      logic       done_res;
      logic       success;
      logic       fault;
   } rsp_type;

endpackage

FILE: rtl/core/irts_csr.sv
// APB-style configuration register file holding the bus operation timeout limit.
// Depends on irts_pkg.
module irts_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [irts_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [irts_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [irts_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready,
   output logic [irts_pkg::TIMEOUT_W-1:0]      timeout_limit
);
   import irts_pkg::*;

   logic [TIMEOUT_W-1:0] timeout_limit_ff;
   logic [TIMEOUT_W-1:0] timeout_limit_in;
   logic                 sel_timeout;
   logic                 wr_en;

   assign sel_timeout = (csr_paddr[CSR_ADDR_W-1] == REG_TIMEOUT_LIMIT);
   assign wr_en       = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready  = 1'b1;

   always_comb begin
      timeout_limit_in = timeout_limit_ff;
      if (wr_en && sel_timeout) begin
         timeout_limit_in = csr_pwdata[TIMEOUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_limit_ff <= TIMEOUT_RESET;
      end else begin
         timeout_limit_ff <= timeout_limit_in;
      end
   end

   assign csr_prdata    = sel_timeout ?
                          {{(CSR_DATA_W-TIMEOUT_W){1'b0}}, timeout_limit_ff} : '0;
   assign timeout_limit = timeout_limit_ff;

endmodule

FILE: rtl/core/i2c_register_transaction_sequencer.sv
// Top level of the I2C register transaction sequencer: input register, phase logic and
// result register.
// Depends on irts_pkg, irts_csr and i2c_register_transaction_sequencer_defines.svh.
//
//   channel  direction  handshake              carries
//   req      in         req_valid / req_ready  command, bus completion or tick word
//   rsp      out        rsp_valid / rsp_ready  next bus operation, read byte, status
//   csr      in         APB-style, pready = 1  timeout_limit at addresses 0-3
//
// A word is taken every cycle unless req_ready is low; each word is held in the input
// register and its result, if any, is written from there into the result register.
// req_ready drops only when a held word would produce a result and the result register is
// full with rsp_ready low. Reset clears the valid flags, the phase and the wait counter.
`include "i2c_register_transaction_sequencer_defines.svh"

module i2c_register_transaction_sequencer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_kind,
   input  logic                                req_is_read,
   input  logic [6:0]                          req_dev_address,
   input  logic [7:0]                          req_reg_index,
   input  logic [7:0]                          req_write_data,
   input  logic [7:0]                          req_length,
   input  logic                                req_ack_seen,
   input  logic [7:0]                          req_rx_byte,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [2:0]                          rsp_bus_op,
   output logic [7:0]                          rsp_bus_byte,
   output logic                                rsp_rx_valid,
   output logic [7:0]                          rsp_rx_data,
   output logic                                rsp_done_res,
   output logic                                rsp_success,
   output logic                                rsp_fault,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [irts_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [irts_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [irts_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);
   import irts_pkg::*;

   typedef enum logic [3:0] {
      PH_IDLE    = 4'd0,
      PH_START   = 4'd1,
      PH_ADDR    = 4'd2,
      PH_REG     = 4'd3,
      PH_DATA    = 4'd4,
      PH_RESTART = 4'd5,
      PH_RADDR   = 4'd6,
      PH_RECV    = 4'd7,
      PH_ACKOUT  = 4'd8,
      PH_STOP    = 4'd9
   } phase_type;

   logic [TIMEOUT_W-1:0] timeout_limit;

   req_type              in_ff, in_in;
   logic                 in_valid_ff, in_valid_in;
   rsp_type              out_ff, out_in;
   logic                 out_valid_ff, out_valid_in;

   phase_type            phase_ff, phase_in;
   logic                 read_mode_ff, read_mode_in;
   logic [6:0]           saved_address_ff, saved_address_in;
   logic [7:0]           saved_register_ff, saved_register_in;
   logic [7:0]           saved_write_byte_ff, saved_write_byte_in;
   logic [7:0]           bytes_left_ff, bytes_left_in;
   logic [TIMEOUT_W-1:0] wait_count_ff, wait_count_in;
   logic                 outcome_ok_ff, outcome_ok_in;

   rsp_type              rsp_calc;
   logic                 emit;
   logic                 step;
   logic                 out_free;
   logic                 req_accept;
   logic [TIMEOUT_W-1:0] wait_inc;
   logic [7:0]           bytes_dec;

   irts_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready),
      .timeout_limit (timeout_limit)
   );

   assign out_free   = !out_valid_ff || rsp_ready;
   assign req_ready  = !in_valid_ff || step;
   assign req_accept = req_valid && req_ready;
   assign wait_inc   = wait_count_ff + 1'b1;
   assign bytes_dec  = bytes_left_ff - 1'b1;

   always_comb begin
      phase_in            = phase_ff;
      read_mode_in        = read_mode_ff;
      saved_address_in    = saved_address_ff;
      saved_register_in   = saved_register_ff;
      saved_write_byte_in = saved_write_byte_ff;
      bytes_left_in       = bytes_left_ff;
      wait_count_in       = wait_count_ff;
      outcome_ok_in       = outcome_ok_ff;
      rsp_calc            = '0;
      emit                = 1'b0;

      if (in_valid_ff) begin
         case (in_ff.kind)
            KIND_CMD: begin
               if (phase_ff == PH_IDLE) begin
                  read_mode_in        = in_ff.is_read;
                  saved_address_in    = in_ff.dev_address;
                  saved_register_in   = in_ff.reg_index;
                  saved_write_byte_in = in_ff.write_data;
                  bytes_left_in       = in_ff.length;
                  outcome_ok_in       = 1'b0;
                  rsp_calc.bus_op     = OP_START;
                  phase_in            = PH_START;
                  wait_count_in       = '0;
                  emit                = 1'b1;
               end
            end
            KIND_DONE: begin
               wait_count_in = '0;
               emit          = 1'b1;
               case (phase_ff)
                  PH_START: begin
                     rsp_calc.bus_op   = OP_SEND;
                     rsp_calc.bus_byte = {saved_address_ff, 1'b0};
                     phase_in          = PH_ADDR;
                  end
                  PH_ADDR: begin
                     if (!in_ff.ack_seen) begin
                        rsp_calc.bus_op = OP_STOP;
                        outcome_ok_in   = 1'b0;
                        phase_in        = PH_STOP;
                     end else begin
                        rsp_calc.bus_op   = OP_SEND;
                        rsp_calc.bus_byte = saved_register_ff |
                           ((read_mode_ff && bytes_left_ff > 8'd1) ? REG_AUTO_INC : 8'd0);
                        phase_in          = PH_REG;
                     end
                  end
                  PH_REG: begin
                     if (!in_ff.ack_seen) begin
                        rsp_calc.bus_op = OP_STOP;
                        outcome_ok_in   = 1'b0;
                        phase_in        = PH_STOP;
                     end else if (read_mode_ff) begin
                        rsp_calc.bus_op = OP_RESTART;
                        phase_in        = PH_RESTART;
                     end else begin
                        rsp_calc.bus_op   = OP_SEND;
                        rsp_calc.bus_byte = saved_write_byte_ff;
                        phase_in          = PH_DATA;
                     end
                  end
                  PH_DATA: begin
                     rsp_calc.bus_op = OP_STOP;
                     outcome_ok_in   = in_ff.ack_seen;
                     phase_in        = PH_STOP;
                  end
                  PH_RESTART: begin
                     rsp_calc.bus_op   = OP_SEND;
                     rsp_calc.bus_byte = {saved_address_ff, ADDR_RD_BIT};
                     phase_in          = PH_RADDR;
                  end
                  PH_RADDR: begin
                     if (!in_ff.ack_seen || bytes_left_ff == 8'd0) begin
                        rsp_calc.bus_op = OP_STOP;
                        outcome_ok_in   = in_ff.ack_seen;
                        phase_in        = PH_STOP;
                     end else begin
                        rsp_calc.bus_op = OP_RECV;
                        phase_in        = PH_RECV;
                     end
                  end
                  PH_RECV: begin
                     bytes_left_in    = bytes_dec;
                     rsp_calc.rx_valid = 1'b1;
                     rsp_calc.rx_data  = in_ff.rx_byte;
                     rsp_calc.bus_op   = (bytes_dec != 8'd0) ? OP_ACK : OP_NACK;
                     phase_in          = PH_ACKOUT;
                  end
                  PH_ACKOUT: begin
                     if (bytes_left_ff != 8'd0) begin
                        rsp_calc.bus_op = OP_RECV;
                        phase_in        = PH_RECV;
                     end else begin
                        rsp_calc.bus_op = OP_STOP;
                        outcome_ok_in   = 1'b1;
                        phase_in        = PH_STOP;
                     end
                  end
                  PH_STOP: begin
                     rsp_calc.done_res = 1'b1;
                     rsp_calc.success  = outcome_ok_ff;
                     phase_in          = PH_IDLE;
                  end
                  default: begin
                     wait_count_in = wait_count_ff;
                     emit          = 1'b0;
                  end
               endcase
            end
            KIND_TICK: begin
               if (phase_ff != PH_IDLE) begin
                  wait_count_in = wait_inc;
                  if (wait_inc >= timeout_limit) begin
                     rsp_calc.fault = 1'b1;
                     phase_in       = PH_IDLE;
                     wait_count_in  = '0;
                     outcome_ok_in  = 1'b0;
                     emit           = 1'b1;
                  end
               end
            end
            default: begin
               emit = 1'b0;
            end
         endcase
      end

      step = in_valid_ff && (!emit || out_free);

      if (!step) begin
         phase_in            = phase_ff;
         read_mode_in        = read_mode_ff;
         saved_address_in    = saved_address_ff;
         saved_register_in   = saved_register_ff;
         saved_write_byte_in = saved_write_byte_ff;
         bytes_left_in       = bytes_left_ff;
         wait_count_in       = wait_count_ff;
         outcome_ok_in       = outcome_ok_ff;
      end
   end

   always_comb begin
      in_in.kind        = req_kind;
      in_in.is_read     = req_is_read;
      in_in.dev_address = req_dev_address;
      in_in.reg_index   = req_reg_index;
      in_in.write_data  = req_write_data;
      in_in.length      = req_length;
      in_in.ack_seen    = req_ack_seen;
      in_in.rx_byte     = req_rx_byte;
      if (!req_accept) begin
         in_in = in_ff;
      end
      in_valid_in  = req_accept || (in_valid_ff && !step);
      out_in       = (step && emit) ? rsp_calc : out_ff;
      out_valid_in = (step && emit) || (out_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      in_ff               <= in_in;
      out_ff              <= out_in;
      read_mode_ff        <= read_mode_in;
      saved_address_ff    <= saved_address_in;
      saved_register_ff   <= saved_register_in;
      saved_write_byte_ff <= saved_write_byte_in;
      bytes_left_ff       <= bytes_left_in;
      outcome_ok_ff       <= outcome_ok_in;
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         phase_ff      <= PH_IDLE;
         wait_count_ff <= '0;
      end else begin
         in_valid_ff   <= in_valid_in;
         out_valid_ff  <= out_valid_in;
         phase_ff      <= phase_in;
         wait_count_ff <= wait_count_in;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_bus_op   = out_ff.bus_op;
   assign rsp_bus_byte = out_ff.bus_byte;
   assign rsp_rx_valid = out_ff.rx_valid;
   assign rsp_rx_data  = out_ff.rx_data;
   assign rsp_done_res = out_ff.done_res;
   assign rsp_success  = out_ff.success;
   assign rsp_fault    = out_ff.fault;

   `IRTS_ASSERT_NOW(a_fault_alone, clock, reset, rsp_valid && rsp_fault,
      (rsp_bus_op == OP_NONE) && !rsp_done_res && !rsp_rx_valid,
      "Fault word carries other fields.")
   `IRTS_ASSERT_NOW(a_rx_with_ack, clock, reset, rsp_valid && rsp_rx_valid,
      (rsp_bus_op == OP_ACK) || (rsp_bus_op == OP_NACK),
      "Received byte without ACK or NACK.")
   `IRTS_ASSERT_NEXT(a_end_idle, clock, reset,
      step && emit && (rsp_calc.fault || rsp_calc.done_res),
      (phase_ff == PH_IDLE) && out_valid_ff,
      "Transaction end did not return to idle.")
   `IRTS_ASSERT_NEXT(a_cmd_start, clock, reset,
      step && (in_ff.kind == KIND_CMD) && (phase_ff == PH_IDLE),
      (phase_ff == PH_START) && out_valid_ff && (out_ff.bus_op == OP_START),
      "Command did not issue start.")

endmodule
